// ===== rtl/core/ust_pkg.sv =====
// Shared types and codes for the unique value set table.
`default_nettype none

package ust_pkg;

   localparam int KindBits     = 2;
   localparam int ItemBits     = 32;
   localparam int PosBits      = 4;
   localparam int CountOutBits = 5;
   localparam int StatusBits   = 2;

   localparam logic [KindBits-1:0] KIND_ADD      = 2'd0;
   localparam logic [KindBits-1:0] KIND_REMOVE   = 2'd1;
   localparam logic [KindBits-1:0] KIND_CONTAINS = 2'd2;
   localparam logic [KindBits-1:0] KIND_READ     = 2'd3;

   localparam logic [StatusBits-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_FULL  = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [StatusBits-1:0]   status;
      logic [CountOutBits-1:0] entry_count;
      logic [ItemBits-1:0]     read_value;
      logic [PosBits-1:0]      found_position;
      logic                    found;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/ust_mem.sv =====
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module ust_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int ABITS = 4
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [ABITS-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [ABITS-1:0] raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ust_ctrl.sv =====
// Sequencer: linear search, append, compacting shift and positional read.
`default_nettype none

module ust_ctrl #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   parameter int CNT_BITS   = 5,
   parameter int ADDR_BITS  = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ust_pkg::KindBits-1:0]      req_kind,
   input  wire logic [ust_pkg::ItemBits-1:0]      req_value,
   input  wire logic [ust_pkg::PosBits-1:0]       req_position,
   output logic                                   res_valid,
   input  wire logic                              res_take,
   output ust_pkg::rsp_type                       res,
   output logic                                   mem_re,
   output logic      [ADDR_BITS-1:0]              mem_raddr,
   input  wire logic [VALUE_BITS-1:0]             mem_rdata,
   output logic                                   mem_we,
   output logic      [ADDR_BITS-1:0]              mem_waddr,
   output logic      [VALUE_BITS-1:0]             mem_wdata
);
   import ust_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RDWAIT,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [KindBits-1:0]     kind_ff, kind_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     iss_ff, iss_in;
   logic [CNT_BITS-1:0]     cmp_ff, cmp_in;
   logic                    cmpv_ff, cmpv_in;
   logic [CNT_BITS-1:0]     wr_ff, wr_in;
   logic                    shv_ff, shv_in;
   logic                    found_ff, found_in;
   logic [PosBits-1:0]      fpos_ff, fpos_in;
   logic [ItemBits-1:0]     rval_ff, rval_in;
   logic [StatusBits-1:0]   status_ff, status_in;

   logic [63:0]             req_wide;
   logic [63:0]             rd_wide;
   logic [31:0]             pos_wide;
   logic [31:0]             cmp_wide;
   logic [31:0]             cnt_wide;
   logic                    issue;

   assign req_wide = {32'b0, req_value};
   assign rd_wide  = 64'(mem_rdata);
   assign pos_wide = 32'(req_position);
   assign cmp_wide = 32'(cmp_ff);
   assign cnt_wide = 32'(count_ff);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      iss_in    = iss_ff;
      cmp_in    = cmp_ff;
      cmpv_in   = 1'b0;
      wr_in     = wr_ff;
      shv_in    = 1'b0;
      found_in  = found_ff;
      fpos_in   = fpos_ff;
      rval_in   = rval_ff;
      status_in = status_ff;
      mem_re    = 1'b0;
      mem_raddr = iss_ff[ADDR_BITS-1:0];
      mem_we    = 1'b0;
      mem_waddr = wr_ff[ADDR_BITS-1:0];
      mem_wdata = mem_rdata;
      issue     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               val_in    = req_wide[VALUE_BITS-1:0];
               found_in  = 1'b0;
               fpos_in   = '0;
               rval_in   = '0;
               status_in = STATUS_OK;
               iss_in    = '0;
               if (req_kind == KIND_READ) begin
                  if (pos_wide < cnt_wide) begin
                     mem_re    = 1'b1;
                     mem_raddr = pos_wide[ADDR_BITS-1:0];
                     state_in  = ST_RDWAIT;
                  end else begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_DONE;
                  end
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // One read is issued per cycle; its data is compared in the next cycle.
            issue = iss_ff < count_ff;
            if (cmpv_ff && (mem_rdata == val_ff)) begin
               found_in = 1'b1;
               fpos_in  = cmp_wide[PosBits-1:0];
               if (kind_ff == KIND_REMOVE) begin
                  iss_in   = cmp_ff + CNT_BITS'(1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (!cmpv_ff && !issue) begin
               if (kind_ff == KIND_ADD) begin
                  if (cnt_wide >= CAPACITY) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[ADDR_BITS-1:0];
                     mem_wdata = val_ff;
                     count_in  = count_ff + CNT_BITS'(1);
                  end
               end
               state_in = ST_DONE;
            end else begin
               mem_re  = issue;
               cmp_in  = iss_ff;
               cmpv_in = issue;
               if (issue) begin
                  iss_in = iss_ff + CNT_BITS'(1);
               end
            end
         end

         ST_SHIFT: begin
            // Entry i+1 is read, then written back to position i.
            issue = iss_ff < count_ff;
            if (shv_ff) begin
               mem_we = 1'b1;
            end
            if (issue) begin
               mem_re  = 1'b1;
               wr_in   = iss_ff - CNT_BITS'(1);
               shv_in  = 1'b1;
               iss_in  = iss_ff + CNT_BITS'(1);
            end else if (!shv_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               state_in = ST_DONE;
            end
         end

         ST_RDWAIT: begin
            rval_in  = rd_wide[ItemBits-1:0];
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cmpv_ff  <= 1'b0;
         shv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmpv_ff  <= cmpv_in;
         shv_ff   <= shv_in;
      end
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      iss_ff    <= iss_in;
      cmp_ff    <= cmp_in;
      wr_ff     <= wr_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      rval_ff   <= rval_in;
      status_ff <= status_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.found          = found_ff;
      res.found_position = fpos_ff;
      res.read_value     = rval_ff;
      res.entry_count    = cnt_wide[CountOutBits-1:0];
      res.status         = status_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/unique_value_set_table.sv =====
// Top level of the unique value set table: stream ports, sequencer, entry store.
`default_nettype none

// A set of distinct values kept packed at positions 0 to count-1 of a single
// on-chip memory with one write port and one registered read port. Each
// request carries an operation in tuser: add appends the value unless it is
// already present (status full when the table holds CAPACITY entries),
// remove deletes it and moves every later entry down one place, contains
// reports whether and where the value is present, and read returns the
// entry at a position (status out of range at or beyond count). Every
// response carries the entry count after the operation. Requests are handled
// one at a time. Add, remove and contains search linearly through the memory
// at one read per cycle and compare each entry against the registered read
// data. Remove of a present value then moves the later entries down, each
// cycle reading one entry and writing the previous one back. A read in
// range reads the memory and returns the registered entry; a read out of
// range responds without a memory read. The next request is accepted only
// after the response has moved into the output register; the slowest
// request is removing any entry but the last from a full table. A finished
// response waits in an output register, so the next request is taken
// while the previous response is still pending. After reset the table is
// empty and no clearing pass is needed, because only positions below count
// are read.
module unique_value_set_table #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: item_value[31:0], position[35:32], zero fill[39:36].
   input  wire logic [39:0] req_tdata,
   // Fields from bit 0: kind[1:0].
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: found[0], found_position[4:1], read_value[36:5],
   // entry_count[41:37], status[43:42], zero fill[47:44].
   output logic      [47:0] rsp_tdata
);
   import ust_pkg::*;

   // Count runs up to CAPACITY itself; addresses only reach CAPACITY-1.
   localparam int CntBits  = $clog2(CAPACITY + 1);
   localparam int AddrBits = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                  res_valid;
   logic                  res_take;
   rsp_type               res;
   logic                  mem_re;
   logic [AddrBits-1:0]   mem_raddr;
   logic [VALUE_BITS-1:0] mem_rdata;
   logic                  mem_we;
   logic [AddrBits-1:0]   mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  slot_free;

   ust_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CntBits),
      .ADDR_BITS  (AddrBits)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_value    (req_tdata[31:0]),
      .req_position (req_tdata[35:32]),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res          (res),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata)
   );

   ust_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS),
      .ABITS (AddrBits)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // The output register takes a new response whenever it is empty or its
   // current response is being taken in the same cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign res_take  = res_valid && slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

endmodule

`default_nettype wire

// ===== rtl/core/ust_chk.sv =====
// Port-level checks for the unique value set table, bound to the top level.
`default_nettype none

module ust_chk #(
   parameter int CAPACITY = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);
   import ust_pkg::*;

   // A pending response holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[41:37]) <= CAPACITY))
      else $error("entry count above capacity");

   // An out-of-range read reports nothing found and no data.
   a_range_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[43:42] == STATUS_RANGE)
         |-> !rsp_tdata[0] && (rsp_tdata[4:1] == 4'd0) && (rsp_tdata[36:5] == 32'd0))
      else $error("out-of-range response carries data");

   // A full table is only reported for absent values and never carries data.
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[43:42] == STATUS_FULL)
         |-> !rsp_tdata[0] && (rsp_tdata[36:5] == 32'd0))
      else $error("full response carries a match or data");

endmodule

bind unique_value_set_table ust_chk #(.CAPACITY(CAPACITY)) u_ust_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== verif/ust_checker.sv =====
// Checker for the unique value set table: predicts each response and compares it.
`timescale 1ns / 100ps

module ust_checker #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // Fields from bit 0: item_value[31:0], position[35:32], zero fill[39:36].
   input  wire logic [39:0] req_tdata,
   // Fields from bit 0: kind[1:0].
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: found[0], found_position[4:1], read_value[36:5],
   // entry_count[41:37], status[43:42], zero fill[47:44].
   input  wire logic [47:0] rsp_tdata,
   output int               fail_count,
   output int               pending_count
);
   import ust_pkg::*;

   logic [31:0] set_vals [CAPACITY];
   int          set_size;
   rsp_type     expected_rsps [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      set_size      = 0;
   end

   // Applies one request to the shadow set and returns the response it should produce.
   function automatic rsp_type apply_set_op(input logic [1:0] op, input logic [31:0] val,
                                            input logic [3:0] pos);
      rsp_type r;
      int      where;
      bit      hit;
      r     = '0;
      where = 0;
      hit   = 1'b0;
      if (op != KIND_READ) begin
         for (int i = 0; i < set_size; i++) begin
            if (!hit && set_vals[i] == val) begin
               hit   = 1'b1;
               where = i;
            end
         end
         r.found          = hit;
         r.found_position = hit ? where[3:0] : 4'd0;
      end
      case (op)
         KIND_ADD: begin
            if (!hit) begin
               if (set_size >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  set_vals[set_size] = val;
                  set_size++;
               end
            end
         end
         KIND_REMOVE: begin
            if (hit) begin
               for (int i = where; i < set_size - 1; i++) set_vals[i] = set_vals[i + 1];
               set_size--;
            end
         end
         KIND_CONTAINS: begin
         end
         default: begin
            if (int'(pos) < set_size) r.read_value = set_vals[pos];
            else r.status = STATUS_RANGE;
         end
      endcase
      r.entry_count = set_size[4:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < 10)
         $display("%0t ust_checker: %s mismatch, expected %0h, got %0h",
                  $realtime, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[43:0]);
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t ust_checker: response %0h with no request outstanding",
                           $realtime, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.found != want.found)
                  report_mismatch("found", want.found, got.found);
               if (got.found_position != want.found_position)
                  report_mismatch("found_position", want.found_position, got.found_position);
               if (got.read_value != want.read_value)
                  report_mismatch("read_value", want.read_value, got.read_value);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", want.entry_count, got.entry_count);
               if (got.status != want.status)
                  report_mismatch("status", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready)
            expected_rsps.push_back(apply_set_op(req_tuser, req_tdata[31:0], req_tdata[35:32]));
      end
      pending_count = expected_rsps.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the unique value set table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

   // The drain and the watchdog are sized well above the longest time from a
   // request to its response when the receiver keeps up (a full search plus a
   // full shift on remove).
   localparam int DrainCycles    = 60;
   localparam int WatchdogLimit  = 4000;
   localparam int ItemsPerPhase  = 170;
   localparam int PoolSize       = 24;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0: item_value[31:0], position[35:32], zero fill[39:36].
   logic [39:0] req_tdata  = '0;
   // Fields from bit 0: kind[1:0].
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0: found[0], found_position[4:1], read_value[36:5],
   // entry_count[41:37], status[43:42], zero fill[47:44].
   logic [47:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Requests draw most values from a small pool so that adds collide with
   // present values, removes find their targets and the table actually fills.
   logic [31:0] value_pool [PoolSize];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   unique_value_set_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ust_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // The receiver decides afresh at every falling edge whether it will take a response.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // The watchdog ends the run when neither channel has moved a request or a
   // response for too long, which would mean the block has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Presents one request at a falling edge, after a random idle gap, and
   // holds it until the block accepts it. The valid stays high afterwards so
   // that back-to-back requests need no extra cycle.
   task automatic send_request(input logic [1:0] op, input logic [31:0] val,
                               input logic [3:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {4'b0000, pos, val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Picks a request whose mix either grows or shrinks the table, so the run
   // passes through empty, partly filled and full tables many times.
   task automatic send_random_request(input bit growing);
      int          pick;
      logic [1:0]  op;
      logic [31:0] val;
      pick = $urandom_range(99);
      if (growing)
         op = (pick < 55) ? ust_pkg::KIND_ADD :
              (pick < 70) ? ust_pkg::KIND_REMOVE :
              (pick < 85) ? ust_pkg::KIND_CONTAINS : ust_pkg::KIND_READ;
      else
         op = (pick < 15) ? ust_pkg::KIND_ADD :
              (pick < 60) ? ust_pkg::KIND_REMOVE :
              (pick < 80) ? ust_pkg::KIND_CONTAINS : ust_pkg::KIND_READ;
      val = ($urandom_range(99) < 85) ? value_pool[$urandom_range(PoolSize - 1)] : $urandom;
      send_request(op, val, 4'($urandom_range(15)));
   endtask

   initial begin
      int remaining;
      bit growing;

      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < PoolSize; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The table starts empty, so a read, a lookup and a
      // remove all miss before anything is stored.
      send_request(ust_pkg::KIND_READ, 32'h0, 4'd0);
      send_request(ust_pkg::KIND_CONTAINS, 32'h0, 4'd0);
      send_request(ust_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 4'd15);

      // The value extremes go in first; adding zero again finds it at position 0.
      send_request(ust_pkg::KIND_ADD, 32'h0000_0000, 4'd0);
      send_request(ust_pkg::KIND_ADD, 32'hFFFF_FFFF, 4'd15);
      send_request(ust_pkg::KIND_ADD, 32'h0000_0000, 4'd0);

      // Fill the table to capacity with distinct values.
      for (int i = 0; i < 14; i++)
         send_request(ust_pkg::KIND_ADD, 32'h1000_0000 + i * 32'h0101_0101, 4'd0);

      // A new value on a full table is refused, while a present one is still found.
      send_request(ust_pkg::KIND_ADD, 32'hDEAD_BEEF, 4'd0);
      send_request(ust_pkg::KIND_ADD, 32'hFFFF_FFFF, 4'd0);
      send_request(ust_pkg::KIND_CONTAINS, 32'h1000_0000 + 13 * 32'h0101_0101, 4'd0);
      send_request(ust_pkg::KIND_READ, 32'h0, 4'd15);

      // Removing the first entry moves all fifteen others down, which empties
      // the last position and puts the top extreme at position 0.
      send_request(ust_pkg::KIND_REMOVE, 32'h0000_0000, 4'd0);
      send_request(ust_pkg::KIND_READ, 32'h0, 4'd15);
      send_request(ust_pkg::KIND_READ, 32'h0, 4'd0);
      send_request(ust_pkg::KIND_REMOVE, 32'h1234_5678, 4'd7);

      // Random part in four phases: no idling, a slow sender, a slow
      // receiver, and both idling now and then.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 72 : (phase == 3) ? 26 : 0;
         rsp_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 26 : 0;
         remaining = 0;
         growing   = 1'b1;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (remaining == 0) begin
               remaining = $urandom_range(40, 10);
               growing   = !growing;
            end
            send_random_request(growing);
            remaining--;
         end
      end

      req_tvalid = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      // Wait for every outstanding response, then a little longer so that a
      // spurious extra response would still be seen by the checker.
      do @(negedge clock); while (pending_count != 0);
      repeat (DrainCycles) @(negedge clock);

      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
